### sv/insertion_sorter_macros.svh
// Assertion macros for the insertion sorter RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

`ifndef ASSERT_OFF
`define ISRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISRT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISRT_ASSERT(label, clk, rst, prop, msg)
`define ISRT_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

### sv/isrt_pkg.sv
// Shared types for the insertion sorter.
// Command and status bundles between controller and datapath; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic insert;
      logic pop;
   } isrt_cmd_type;

   typedef struct packed {
      logic out_full;
      logic last_one;
   } isrt_sts_type;

endpackage

`default_nettype wire

### sv/isrt_ctrl.sv
// Insertion sorter controller: fill and drain sequencing.
// Uses isrt_pkg command/status types.
`timescale 1ns / 1ps
`default_nettype none

module isrt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_stall,
   input  wire logic                  rsp_stall,
   input  wire isrt_pkg::isrt_sts_type sts,
   output isrt_pkg::isrt_cmd_type     cmd
);

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff, state_in;
   logic slot_free;

   assign slot_free = !sts.out_full || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      case (state_ff)
         ST_FILL: begin
            req_stall  = 1'b0;
            cmd.insert = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.pop = slot_free;
            if (slot_free && sts.last_one) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/isrt_dpath.sv
// Insertion sorter datapath: row of sorted cells, count, overflow flag, output register.
// Uses isrt_pkg types and insertion_sorter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "insertion_sorter_macros.svh"

module isrt_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire isrt_pkg::isrt_cmd_type       cmd,
   output isrt_pkg::isrt_sts_type            sts,
   input  wire logic signed [isrt_pkg::VALUE_W-1:0] req_value,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic signed [isrt_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_run,
   output logic                              rsp_overflowed
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [isrt_pkg::VALUE_W-1:0] store_ff [DEPTH];
   logic signed [isrt_pkg::VALUE_W-1:0] below_val [DEPTH];
   logic signed [isrt_pkg::VALUE_W-1:0] above_val [DEPTH];
   logic [DEPTH-1:0] gt;
   logic [DEPTH-1:0] below_gt;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             full;
   logic             do_insert;

   logic                                rsp_valid_ff;
   logic signed [isrt_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                                rsp_end_ff;
   logic                                rsp_ovf_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign do_insert = cmd.insert && !full;

   genvar i;
   for (i = 0; i < DEPTH; i++) begin : g_cell
      assign gt[i] = (CW'(i) < count_ff) && (store_ff[i] > req_value);

      if (i == 0) begin : g_first
         assign below_gt[i]  = 1'b0;
         assign below_val[i] = store_ff[i];
      end else begin : g_rest
         assign below_gt[i]  = gt[i-1];
         assign below_val[i] = store_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign above_val[i] = store_ff[i];
      end else begin : g_mid
         assign above_val[i] = store_ff[i+1];
      end

      // shift up above the insertion point, drop the value in at it, shift down on pop
      always_ff @(posedge clock) begin
         if (do_insert) begin
            if (below_gt[i]) begin
               store_ff[i] <= below_val[i];
            end else if (gt[i] || (CW'(i) >= count_ff)) begin
               store_ff[i] <= req_value;
            end
         end else if (cmd.pop) begin
            store_ff[i] <= above_val[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.insert) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         if (sts.last_one) begin
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (cmd.pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rsp_value_ff <= store_ff[0];
         rsp_end_ff   <= sts.last_one;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign sts.out_full = rsp_valid_ff;
   assign sts.last_one = (count_ff == CW'(1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_end_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   `ISRT_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   `ISRT_ASSERT(a_pop_nonempty, clock, reset, cmd.pop |-> count_ff != '0, "pop from empty store")
   `ISRT_ASSERT(a_run_close, clock, reset, (cmd.pop && sts.last_one) |=> (count_ff == '0 && !ovf_ff), "run not closed")
   `ISRT_ASSERT(a_no_overlap, clock, reset, !(cmd.insert && cmd.pop), "insert and pop together")

endmodule

`default_nettype wire

### sv/insertion_sorter.sv
// Insertion sorter top level: controller plus datapath.
// Uses isrt_pkg, isrt_ctrl and isrt_dpath.
// Values of a run enter one request per cycle and are placed at once into an ascending row
// of DEPTH registers, each cell comparing against the new value and shifting up in the same
// cycle; equal values keep arrival order. The request flagged last is inserted, after which
// requests are stalled while the row shifts down toward the output register, giving one
// sorted result per cycle unless the result side stalls. Values past DEPTH are dropped and
// every result of that run carries the overflow flag; end_of_run marks the final result,
// after which the next run may start.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter #(
   parameter int DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [isrt_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [isrt_pkg::VALUE_W-1:0]      rsp_sorted_value,
   output logic                                     rsp_end_of_run,
   output logic                                     rsp_overflowed
);

   isrt_pkg::isrt_cmd_type cmd;
   isrt_pkg::isrt_sts_type sts;

   isrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   isrt_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

`default_nettype wire
